// ===== rtl/xrr_pkg.sv =====
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared types and constants of the ranged xorshift128 generator.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int DataW = 32;
  localparam int CfgIdxW = 2;

  localparam logic [DataW-1:0] SEED_A_RST = 32'd123456789;
  localparam logic [DataW-1:0] SEED_B_RST = 32'd362436069;
  localparam logic [DataW-1:0] SEED_C_RST = 32'd521288629;
  localparam logic [DataW-1:0] SEED_D_RST = 32'd88675123;

  localparam logic [CfgIdxW-1:0] CFG_SEED_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEED_C = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEED_D = 2'd3;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_STEP,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
    logic [DataW-1:0] d;
  } seeds_t;

endpackage

// ===== rtl/xrr_gen.sv =====
// ----------------------------------------------------------------------------
// xrr_gen
// Four-word xorshift128 state with seed load and single-step advance.
// ----------------------------------------------------------------------------
module xrr_gen (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  xrr_pkg::gen_ctrl_t      ctrl_i,
  input  xrr_pkg::seeds_t         seeds_i,
  output logic [xrr_pkg::DataW-1:0] next_word_o
);
  import xrr_pkg::*;

  logic [DataW-1:0] x_q, y_q, z_q, w_q;
  logic [DataW-1:0] x_d, y_d, z_d, w_d;
  logic [DataW-1:0] t1, t2, nx;

  always_comb begin
    t1 = w_q ^ (w_q << 11);
    t2 = t1 ^ (t1 >> 8);
    nx = t2 ^ x_q ^ (x_q >> 19);
  end

  assign next_word_o = nx;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    w_d = w_q;
    if (ctrl_i.load) begin
      x_d = seeds_i.a;
      y_d = seeds_i.b;
      z_d = seeds_i.c;
      w_d = seeds_i.d;
    end else if (ctrl_i.step) begin
      x_d = nx;
      y_d = x_q;
      z_d = y_q;
      w_d = z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= SEED_A_RST;
      y_q <= SEED_B_RST;
      z_q <= SEED_C_RST;
      w_q <= SEED_D_RST;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      w_q <= w_d;
    end
  end

endmodule

// ===== rtl/xrr_div.sv =====
// ----------------------------------------------------------------------------
// xrr_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xrr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [xrr_pkg::DataW-1:0] dividend_i,
  input  logic [xrr_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [xrr_pkg::DataW-1:0] rem_o
);
  import xrr_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW:0]  rem_q, rem_d;
  logic [DataW-1:0] dvd_q, dvd_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic [DataW:0]  shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    shifted = {rem_q[DataW-1:0], dvd_q[DataW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DataW-2:0], 1'b0};
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = shifted - {1'b0, dsr_q};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DataW-1:0];

endmodule

// ===== rtl/xorshift128_ranged_random.sv =====
// ----------------------------------------------------------------------------
// xorshift128_ranged_random
// xorshift128 generator with range reduction and reseed with warm-up.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o   | op_i, range_low_i, range_high_i
//   output   | out_valid_o / out_stall_i | value_o
//   config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// An empty or one-value range skips the generator, the full range takes the
// generator word as is, a ranged draw goes through the remainder unit and a
// reseed steps the generator WARMUP_STEPS times, one generator step per cycle.
// The next input transfer can come in the cycle after the result is loaded.
// One item in work; in_stall_o is high until its result is loaded.
// Reset loads the default seeds into the state; no warm-up at reset.
// A finished result waits in its own register while the output stalls.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random #(
  parameter int WARMUP_STEPS = 5000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xrr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [xrr_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [xrr_pkg::DataW-1:0]   range_low_i,
  input  logic [xrr_pkg::DataW-1:0]   range_high_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xrr_pkg::DataW-1:0]   value_o
);
  import xrr_pkg::*;

  localparam int CntW = (WARMUP_STEPS < 2) ? 1 : $clog2(WARMUP_STEPS + 1);

  state_e           state_q, state_d;
  seeds_t           seeds_q, seeds_d;
  logic [CntW-1:0]  warm_q, warm_d;
  logic [DataW-1:0] low_q, low_d;
  logic [DataW-1:0] span_q, span_d;
  logic [DataW-1:0] res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] value_q, value_d;
  logic             in_xfer;
  gen_ctrl_t        gen_ctrl;
  logic [DataW-1:0] next_word;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_rem;

  always_comb begin
    seeds_d = seeds_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED_A: seeds_d.a = cfg_data_i;
        CFG_SEED_B: seeds_d.b = cfg_data_i;
        CFG_SEED_C: seeds_d.c = cfg_data_i;
        CFG_SEED_D: seeds_d.d = cfg_data_i;
        default: seeds_d = seeds_q;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    warm_d      = warm_q;
    low_d       = low_q;
    span_d      = span_q;
    res_d       = res_q;
    gen_ctrl    = '0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op_i == OP_RESEED) begin
            gen_ctrl.load = 1'b1;
            warm_d        = CntW'(WARMUP_STEPS);
            state_d       = ST_WARM;
          end else if (range_low_i >= range_high_i) begin
            res_d   = range_high_i;
            state_d = ST_RESULT;
          end else begin
            low_d   = range_low_i;
            span_d  = range_high_i - range_low_i + 1'b1;
            state_d = ST_STEP;
          end
        end
      end
      ST_WARM: begin
        if (warm_q == '0) begin
          res_d   = '0;
          state_d = ST_RESULT;
        end else begin
          gen_ctrl.step = 1'b1;
          warm_d        = warm_q - 1'b1;
        end
      end
      ST_STEP: begin
        gen_ctrl.step = 1'b1;
        if (span_q == '0) begin
          res_d   = next_word;
          state_d = ST_RESULT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d   = low_q + div_rem;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
      seeds_q     <= '{a: SEED_A_RST, b: SEED_B_RST, c: SEED_C_RST, d: SEED_D_RST};
    end else begin
      state_q     <= state_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
      seeds_q     <= seeds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    span_q  <= span_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  xrr_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (gen_ctrl),
    .seeds_i     (seeds_q),
    .next_word_o (next_word)
  );

  xrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (next_word),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule
